// ----- design/lpa_pkg.sv -----
// Shared types and constants for the linked pool allocator.
package lpa_pkg;

	localparam int NODE_W        = 10;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 11;
	localparam int POOL_SIZE_DEF = 1024;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_ACTIVE = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node;
	} req_word_t;

	typedef struct packed {
		status_t            status;
		logic [NODE_W-1:0]  granted;
		logic [COUNT_W-1:0] active_count;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_PUSH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;
		logic rd_issue;
		logic alloc_commit;
		logic free_unlink;
		logic free_push;
		logic reject;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic idle_empty;
		logic free_ok;
		op_t  op;
	} sts_t;

endpackage

// ----- design/lpa_ctrl.sv -----
// Sequencing state machine and result handshake for the linked pool allocator.
module lpa_ctrl import lpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;
	logic   rsp_valid_q;
	logic   can_emit;
	logic   emit;

	assign can_emit  = !rsp_valid_q || !rsp_stall;
	assign emit      = cmd.alloc_commit || cmd.free_push || cmd.reject;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done)
					state_nx = S_IDLE;
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.rd_issue = 1'b1;
					state_nx     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.op == OP_ALLOC) begin
					if (can_emit) begin
						cmd.alloc_commit = !sts.idle_empty;
						cmd.reject       = sts.idle_empty;
						state_nx         = S_IDLE;
					end
				end else if (sts.free_ok) begin
					cmd.free_unlink = 1'b1;
					state_nx        = S_PUSH;
				end else if (can_emit) begin
					cmd.reject = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_PUSH: begin
				if (can_emit) begin
					cmd.free_push = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			default: begin
				state_nx = S_CLEAR;
			end
		endcase
	end

endmodule

// ----- design/lpa_dpath.sv -----
// Link memories, list heads, active total and result register of the allocator.
module lpa_dpath import lpa_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t req_word,
	input  cmd_t      cmd,
	output sts_t      sts,
	output rsp_word_t rsp_word
);

	localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int LINK_W = $clog2(POOL_SIZE + 1);
	localparam int CMP_W  = (LINK_W > NODE_W) ? LINK_W : NODE_W;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SIZE);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_SIZE - 1);

	logic [LINK_W-1:0] next_mem_q [POOL_SIZE];
	logic [LINK_W-1:0] prev_mem_q [POOL_SIZE];
	logic              act_mem_q  [POOL_SIZE];

	logic [LINK_W-1:0] next_rd_q, prev_rd_q;
	logic              act_rd_q;
	op_t               op_q;
	logic [NODE_W-1:0] node_q;
	logic [IDX_W-1:0]  clr_q;
	logic [LINK_W-1:0] idle_head_q, active_head_q, total_q;
	rsp_word_t         rsp_q;

	logic [IDX_W-1:0]  req_idx, node_idx, next_ra;
	logic [LINK_W-1:0] node_link, prev_eff, total_nx;
	logic              node_is_head, emit;

	logic              nx_we, pv_we, ac_we;
	logic [IDX_W-1:0]  nx_wa, pv_wa, ac_wa;
	logic [LINK_W-1:0] nx_wd, pv_wd;
	logic              ac_wd;

	assign req_idx      = IDX_W'(req_word.node);
	assign node_idx     = IDX_W'(node_q);
	assign node_link    = LINK_W'(node_q);
	assign next_ra      = (req_word.op == OP_ALLOC) ? idle_head_q[IDX_W-1:0] : req_idx;
	assign node_is_head = (node_link == active_head_q);
	// the head's stored prev link is stale; it is null by definition
	assign prev_eff     = node_is_head ? LINK_NULL : prev_rd_q;

	assign sts.clear_done = (clr_q == LAST_IDX);
	assign sts.idle_empty = (idle_head_q == LINK_NULL);
	assign sts.free_ok    = (CMP_W'(node_q) < CMP_W'(POOL_SIZE)) && act_rd_q;
	assign sts.op         = op_q;

	// write port selection
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		ac_we = 1'b0; ac_wa = '0; ac_wd = 1'b0;
		if (cmd.clear_step) begin
			nx_we = 1'b1; nx_wa = clr_q; nx_wd = LINK_W'(clr_q) + LINK_W'(1);
			pv_we = 1'b1; pv_wa = clr_q;
			pv_wd = (clr_q == '0) ? LINK_NULL : LINK_W'(clr_q) - LINK_W'(1);
			ac_we = 1'b1; ac_wa = clr_q; ac_wd = 1'b0;
		end else if (cmd.alloc_commit) begin
			nx_we = 1'b1; nx_wa = idle_head_q[IDX_W-1:0]; nx_wd = active_head_q;
			pv_we = (active_head_q != LINK_NULL);
			pv_wa = active_head_q[IDX_W-1:0]; pv_wd = idle_head_q;
			ac_we = 1'b1; ac_wa = idle_head_q[IDX_W-1:0]; ac_wd = 1'b1;
		end else if (cmd.free_unlink) begin
			nx_we = (prev_eff != LINK_NULL);
			nx_wa = prev_eff[IDX_W-1:0]; nx_wd = next_rd_q;
			pv_we = (next_rd_q != LINK_NULL);
			pv_wa = next_rd_q[IDX_W-1:0]; pv_wd = prev_eff;
			ac_we = 1'b1; ac_wa = node_idx; ac_wd = 1'b0;
		end else if (cmd.free_push) begin
			nx_we = 1'b1; nx_wa = node_idx; nx_wd = idle_head_q;
			pv_we = (idle_head_q != LINK_NULL);
			pv_wa = idle_head_q[IDX_W-1:0]; pv_wd = node_link;
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we)
			next_mem_q[nx_wa] <= nx_wd;
		if (cmd.rd_issue)
			next_rd_q <= next_mem_q[next_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we)
			prev_mem_q[pv_wa] <= pv_wd;
		if (cmd.rd_issue)
			prev_rd_q <= prev_mem_q[req_idx];
	end

	always_ff @(posedge clk) begin
		if (ac_we)
			act_mem_q[ac_wa] <= ac_wd;
		if (cmd.rd_issue)
			act_rd_q <= act_mem_q[req_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			op_q   <= req_word.op;
			node_q <= req_word.node;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			idle_head_q   <= '0;
			active_head_q <= LINK_NULL;
			total_q       <= '0;
		end else begin
			if (cmd.clear_step)
				clr_q <= clr_q + IDX_W'(1);
			if (cmd.alloc_commit) begin
				idle_head_q   <= next_rd_q;
				active_head_q <= idle_head_q;
			end
			if (cmd.free_unlink && node_is_head)
				active_head_q <= next_rd_q;
			if (cmd.free_push)
				idle_head_q <= node_link;
			total_q <= total_nx;
		end
	end

	always_comb begin
		total_nx = total_q;
		if (cmd.alloc_commit)
			total_nx = total_q + LINK_W'(1);
		else if (cmd.free_push)
			total_nx = total_q - LINK_W'(1);
	end

	assign emit = cmd.alloc_commit || cmd.free_push || cmd.reject;

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.reject)
				rsp_q.status <= (op_q == OP_ALLOC) ? ST_EMPTY : ST_NOT_ACTIVE;
			else
				rsp_q.status <= ST_OK;
			rsp_q.granted      <= cmd.alloc_commit ? NODE_W'(idle_head_q) : '0;
			rsp_q.active_count <= COUNT_W'(total_nx);
		end
	end

	assign rsp_word = rsp_q;

endmodule

// ----- design/linked_pool_allocator.sv -----
// Top level of the linked pool allocator: controller, datapath and checks.
//
// Keeps POOL_SIZE nodes on an idle and an active doubly linked list. A request
// word either allocates (takes the idle head, pushes it on the active list)
// or frees a named node (unlinks it from the active list, pushes it on the
// idle list); each request gives exactly one response word with a status,
// the granted node and the active count. A free of a node that is not active
// or out of range is refused with status NOT_ACTIVE and changes nothing.
// After reset the link memories are initialised by a clearing pass over all
// POOL_SIZE entries, one entry per cycle, during which req_stall stays high.
// Sequencing: the link memories have one write port and a registered read each,
// so an allocate or a refused request goes through a read step and then a commit
// step (the response word is registered at the commit), and a successful free
// goes through reading the node's links, rewriting its neighbours and pushing the
// node (the response is registered at the push). The next request is taken in
// the cycle after the response is loaded; a stalled response only holds the
// block once a second response is ready.
module linked_pool_allocator import lpa_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);

	cmd_t cmd;
	sts_t sts;

	lpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpa_dpath #(
		.POOL_SIZE (POOL_SIZE)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_word (rsp_word)
	);

	// a taken request keeps the block busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous one in flight");

	// refused requests never grant a node
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.status != ST_OK) |-> (rsp_word.granted == '0))
		else $error("granted node on refused request");

	// pool empty only when every node is active
	a_empty_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.status == ST_EMPTY)
			|-> (rsp_word.active_count == COUNT_W'(POOL_SIZE)))
		else $error("empty reported with idle nodes left");

	// at most one controller action per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_step, cmd.rd_issue, cmd.alloc_commit,
			cmd.free_unlink, cmd.free_push, cmd.reject}))
		else $error("conflicting datapath commands");

endmodule
